// ===== rtl/dsv_pkg.sv =====
`default_nettype none
package dsv_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned FIELD_W = 7;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = YEAR_W;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_YEAR = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_YEAR = 1'd1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1970;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2999;

    // character positions in the text
    localparam logic [POS_W-1:0] POS_YEAR_HI  = 5'd1;
    localparam logic [POS_W-1:0] POS_YEAR_LO0 = 5'd2;
    localparam logic [POS_W-1:0] POS_YEAR_LO1 = 5'd3;
    localparam logic [POS_W-1:0] POS_DASH1    = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH2    = 5'd7;
    localparam logic [POS_W-1:0] POS_SPACE    = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON1   = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON2   = 5'd16;
    localparam logic [POS_W-1:0] TEXT_LEN     = 5'd19;
    localparam logic [POS_W-1:0] POS_SAT      = 5'd20;

    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [FIELD_W-1:0] MINSEC_MAX = 7'd59;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
        logic [FIELD_W-1:0] year_lo;
        logic [1:0]         cent_mod4;
        logic               shape_err;
        logic               len_ok;
    } t_fields;

    function automatic logic [FIELD_W-1:0] month_len(input logic [FIELD_W-1:0] month,
                                                     input logic leap);
        logic [FIELD_W-1:0] len;
        case (month)
            7'd2:                       len = leap ? 7'd29 : 7'd28;
            7'd4, 7'd6, 7'd9, 7'd11:    len = 7'd30;
            default:                    len = 7'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dsv_in_stage.sv =====
`default_nettype none
module dsv_in_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [dsv_pkg::CHAR_W-1:0] i_char,
    input  wire logic                       i_last,
    input  wire logic                       i_adv,
    output logic                            o_ready,
    output logic                            o_valid,
    output logic [dsv_pkg::CHAR_W-1:0]      o_char,
    output logic                            o_last
);
    import dsv_pkg::*;

    logic              r_vld;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;

    assign o_ready = !r_vld || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

    assign o_valid = r_vld;
    assign o_char  = r_char;
    assign o_last  = r_last;
endmodule
`default_nettype wire

// ===== rtl/dsv_accum.sv =====
`default_nettype none
module dsv_accum (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [dsv_pkg::CHAR_W-1:0] i_char,
    input  wire logic                       i_last,
    output dsv_pkg::t_fields                o_fields
);
    import dsv_pkg::*;

    logic [POS_W-1:0]   r_pos,    n_pos;
    logic               r_shape,  n_shape;
    logic [YEAR_W-1:0]  r_year,   n_year;
    logic [FIELD_W-1:0] r_month,  n_month;
    logic [FIELD_W-1:0] r_day,    n_day;
    logic [FIELD_W-1:0] r_hour,   n_hour;
    logic [FIELD_W-1:0] r_minute, n_minute;
    logic [FIELD_W-1:0] r_second, n_second;
    logic [FIELD_W-1:0] r_ylo,    n_ylo;
    logic [1:0]         r_cent,   n_cent;

    logic       is_digit;
    logic [3:0] digit;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit    = i_char[3:0];

    always_comb begin
        n_pos    = (r_pos < POS_SAT) ? r_pos + 5'd1 : r_pos;
        n_shape  = r_shape;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_ylo    = r_ylo;
        n_cent   = r_cent;
        if (r_pos < TEXT_LEN) begin
            case (r_pos)
                POS_DASH1, POS_DASH2: begin
                    if (i_char != CH_DASH) n_shape = 1'b1;
                end
                POS_SPACE: begin
                    if (i_char != CH_SPACE) n_shape = 1'b1;
                end
                POS_COLON1, POS_COLON2: begin
                    if (i_char != CH_COLON) n_shape = 1'b1;
                end
                default: begin
                    if (!is_digit) begin
                        n_shape = 1'b1;
                    end else if (r_pos < POS_DASH1) begin
                        n_year = 14'(r_year * 14'd10 + 14'(digit));
                        if (r_pos == POS_YEAR_HI) n_cent = n_year[1:0];
                        if (r_pos == POS_YEAR_LO0) n_ylo = 7'(digit);
                        if (r_pos == POS_YEAR_LO1) n_ylo = 7'(r_ylo * 7'd10 + 7'(digit));
                    end else if (r_pos < POS_DASH2) begin
                        n_month = 7'(r_month * 7'd10 + 7'(digit));
                    end else if (r_pos < POS_SPACE) begin
                        n_day = 7'(r_day * 7'd10 + 7'(digit));
                    end else if (r_pos < POS_COLON1) begin
                        n_hour = 7'(r_hour * 7'd10 + 7'(digit));
                    end else if (r_pos < POS_COLON2) begin
                        n_minute = 7'(r_minute * 7'd10 + 7'(digit));
                    end else begin
                        n_second = 7'(r_second * 7'd10 + 7'(digit));
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_pos    <= '0;
            r_shape  <= 1'b0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_ylo    <= '0;
            r_cent   <= '0;
        end else if (i_adv) begin
            r_pos    <= n_pos;
            r_shape  <= n_shape;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_ylo    <= n_ylo;
            r_cent   <= n_cent;
        end
    end

    always_comb begin
        o_fields.year      = n_year;
        o_fields.month     = n_month;
        o_fields.day       = n_day;
        o_fields.hour      = n_hour;
        o_fields.minute    = n_minute;
        o_fields.second    = n_second;
        o_fields.year_lo   = n_ylo;
        o_fields.cent_mod4 = n_cent;
        o_fields.shape_err = n_shape;
        o_fields.len_ok    = (n_pos == TEXT_LEN);
    end
endmodule
`default_nettype wire

// ===== rtl/dsv_out_stage.sv =====
`default_nettype none
module dsv_out_stage (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_load,
    input  wire dsv_pkg::t_fields           i_fields,
    input  wire logic [dsv_pkg::YEAR_W-1:0] i_min_year,
    input  wire logic [dsv_pkg::YEAR_W-1:0] i_max_year,
    input  wire logic                       i_ready,
    output logic                            o_valid,
    output logic                            o_res
);
    import dsv_pkg::*;

    logic r_vld;
    logic r_res;
    logic leap;
    logic ok;

    // year = hundreds * 100 + year_lo, so leap rules reduce to the low bits
    assign leap = (i_fields.year_lo != '0) ? (i_fields.year_lo[1:0] == 2'd0)
                                           : (i_fields.cent_mod4 == 2'd0);

    assign ok = !i_fields.shape_err && i_fields.len_ok
             && (i_fields.year >= i_min_year) && (i_fields.year <= i_max_year)
             && (i_fields.month != '0) && (i_fields.month <= MONTH_MAX)
             && (i_fields.day != '0) && (i_fields.day <= month_len(i_fields.month, leap))
             && (i_fields.hour <= HOUR_MAX)
             && (i_fields.minute <= MINSEC_MAX)
             && (i_fields.second <= MINSEC_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= ok;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;
endmodule
`default_nettype wire

// ===== rtl/datetime_string_validator_top.sv =====
// Date-and-time text checker for the form YYYY-MM-DD HH:MM:SS.
// Input stream (s_axis): one character per word in tdata, tlast on the final
// character of each text. Output stream (m_axis): one verdict word per text,
// tdata bit 0 is 1 when the text is a valid date and time within the year
// bounds, else 0.
// Config port: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
// (0: min_year, 1: max_year); write only while no text is in flight.
// The verdict shows on m_axis after the final character is accepted and passes
// through the input register, then one pass into the result register.
// Throughput: one character per cycle, sustained; s_axis_tready drops only
// when a verdict is waiting in the result register, m_axis_tready is low and
// the next final character is ready to be judged. Non-final characters keep
// flowing under an output stall.
// Reset (synchronous, active low) empties both registers, clears all partial
// fields and sets the year bounds to 1970 and 2999.
`default_nettype none
module datetime_string_validator_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [dsv_pkg::CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
    input  wire logic                           s_axis_tlast,   // last_char
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [dsv_pkg::OUT_DATA_W-1:0]      m_axis_tdata,   // [0] valid_res, [7:1] zero
    input  wire logic                           i_cfg_we,
    input  wire logic [dsv_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [dsv_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import dsv_pkg::*;

    logic [YEAR_W-1:0] r_min_year;
    logic [YEAR_W-1:0] r_max_year;

    logic              in_vld;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
    logic              adv;
    logic              out_vld;
    logic              out_res;
    t_fields           fields;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_year <= MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MIN_YEAR: r_min_year <= i_cfg_wdata;
                REG_MAX_YEAR: r_max_year <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // a final character waits only while the result register is held
    assign adv = in_vld && (!in_last || !out_vld || m_axis_tready);

    dsv_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_adv   (adv),
        .o_ready (s_axis_tready),
        .o_valid (in_vld),
        .o_char  (in_char),
        .o_last  (in_last)
    );

    dsv_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_char   (in_char),
        .i_last   (in_last),
        .o_fields (fields)
    );

    dsv_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv && in_last),
        .i_fields   (fields),
        .i_min_year (r_min_year),
        .i_max_year (r_max_year),
        .i_ready    (m_axis_tready),
        .o_valid    (out_vld),
        .o_res      (out_res)
    );

    assign m_axis_tvalid = out_vld;
    assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_res};
endmodule
`default_nettype wire

// ===== rtl/dsv_checker.sv =====
`default_nettype none
module dsv_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           s_axis_tlast,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [dsv_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import dsv_pkg::*;

    // stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict dropped or changed under stall");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:1] == '0))
        else $error("padding bits of verdict not zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict valid right after reset");

    // a final character taken with the output empty yields a verdict through the input and result registers
    a_verdict_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid
        |=> ##1 m_axis_tvalid)
        else $error("verdict missing after final character");
endmodule

bind datetime_string_validator_top dsv_checker u_dsv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
